@@ hdl/ufl_pkg.sv @@
// ----------------------------------------------------------------------------
// UTCDFS flux limiter package
// Shared constants and types for the flux limiter pipeline.
// ----------------------------------------------------------------------------
package ufl_pkg;

   localparam int DATA_WIDTH   = 32;
   localparam int FRAC_BITS    = 16;
   localparam int PHI_WIDTH    = FRAC_BITS + 2;
   localparam int DIV_STEPS    = 16;
   localparam int REM_WIDTH    = 64;
   localparam int CAP_WIDTH    = 33;
   localparam int CAPQ_WIDTH   = 17;
   localparam int PROD_WIDTH   = PHI_WIDTH + DATA_WIDTH;
   // Input register, two multiplier stages, divider set-up, divider steps,
   // limiter select, product and saturation.
   localparam int PIPE_LATENCY = 4 + DIV_STEPS + 3;

   // Branch of the piecewise limiter that a ratio falls in.
   typedef enum logic [2:0] {
      BR_NEG_FAR,
      BR_NEG_ZERO,
      BR_POLY,
      BR_LINEAR,
      BR_HIGH
   } branch_type;

   // Side information that travels with each item down the pipeline.
   typedef struct packed {
      branch_type             branch;
      logic                   mode;
      logic [DATA_WIDTH-1:0]  grad;
   } tag_type;

endpackage

@@ hdl/utcdfs_flux_limiter_core.sv @@
// ----------------------------------------------------------------------------
// UTCDFS flux limiter core
// Computes phi(r) and phi(r) * gradient for one element per clock cycle.
// ----------------------------------------------------------------------------
// A new element may be started in every clock cycle; busy is always low.
// Each element passes from the start transfer through the 16-step restoring
// divider that forms the rational branches and the right-side cap, plus
// seven stages of input, multiply, set-up, select and saturation. Results
// leave in start order and are held on the rsp_ ports for a single cycle,
// marked by rsp_valid; the receiver cannot stall them.
module utcdfs_flux_limiter_core
   import ufl_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [DATA_WIDTH-1:0]   req_ratio,
   input  logic [DATA_WIDTH-1:0]   req_gradient,
   input  logic                    req_mode,
   output logic                    rsp_valid,
   output logic [DATA_WIDTH-1:0]   rsp_limited_gradient,
   output logic [PHI_WIDTH-1:0]    rsp_limiter_value
);

   // The pipeline never stalls.
   assign busy = 1'b0;

   // ---------------- Stage 0: input register --------------------------------
   logic                  v0_ff;
   logic [DATA_WIDTH-1:0] ratio0_ff;
   tag_type               tag0_ff;
   branch_type            branch0_in;

   always_comb begin
      if ($signed(req_ratio) < -32'sd65536) begin
         branch0_in = BR_NEG_FAR;
      end else if (req_ratio[DATA_WIDTH-1]) begin
         branch0_in = BR_NEG_ZERO;
      end else if (req_ratio < 32'd32768) begin
         branch0_in = BR_POLY;
      end else if (req_ratio < 32'd131072) begin
         branch0_in = BR_LINEAR;
      end else begin
         branch0_in = BR_HIGH;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else begin
         v0_ff <= start & ~busy;
      end
      ratio0_ff      <= req_ratio;
      tag0_ff.branch <= branch0_in;
      tag0_ff.mode   <= req_mode;
      tag0_ff.grad   <= req_gradient;
   end

   // ---------------- Stage 1: magnitude products ----------------------------
   // x is |r|; m1 = x(x-1) and m2 = x^2 in raw fixed-point units.
   logic [DATA_WIDTH-1:0] x1_in, y1_in;
   logic [REM_WIDTH-1:0]  m1_in, m2_in;
   logic                  v1_ff;
   logic [REM_WIDTH-1:0]  m1_1_ff, m2_1_ff;
   logic [16:0]           x1_ff;
   logic [CAP_WIDTH-1:0]  cden1_ff;
   tag_type               tag1_ff;

   assign x1_in = ratio0_ff[DATA_WIDTH-1] ? (32'd0 - ratio0_ff) : ratio0_ff;
   assign y1_in = x1_in - 32'h0001_0000;
   assign m1_in = {32'd0, x1_in} * {32'd0, y1_in};
   assign m2_in = {32'd0, x1_in} * {32'd0, x1_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= v0_ff;
      end
      m1_1_ff  <= m1_in;
      m2_1_ff  <= m2_in;
      x1_ff    <= x1_in[16:0];
      cden1_ff <= {1'b0, x1_in} + 33'h0_0001_0000;
      tag1_ff  <= tag0_ff;
   end

   // ---------------- Stage 2: cube for the polynomial branch ----------------
   logic [44:0]          r3_in;
   logic                 v2_ff;
   logic [REM_WIDTH-1:0] m1_2_ff, m2_2_ff;
   logic [44:0]          r3_2_ff;
   logic [16:0]          x2_ff;
   logic [CAP_WIDTH-1:0] cden2_ff;
   tag_type              tag2_ff;

   assign r3_in = {15'd0, m2_1_ff[29:0]} * {30'd0, x1_ff[14:0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      m1_2_ff  <= m1_1_ff;
      m2_2_ff  <= m2_1_ff;
      r3_2_ff  <= r3_in;
      x2_ff    <= x1_ff;
      cden2_ff <= cden1_ff;
      tag2_ff  <= tag1_ff;
   end

   // ---------------- Stage 3: polynomial values and divider set-up ----------
   logic [49:0]           poly_acc;
   logic [19:0]           lin_acc;
   logic [PHI_WIDTH-1:0]  early_in;
   logic [REM_WIDTH-1:0]  rem_init, den_init;
   logic [CAP_WIDTH:0]    cap_top;
   logic [CAP_WIDTH-1:0]  crem_init;
   logic                  cq_init;

   assign poly_acc = {5'd0, r3_2_ff} + (50'(x2_ff[14:0]) << 33)
                     - (50'(m2_2_ff[29:0]) << 17);
   assign lin_acc  = 20'(x2_ff) * 20'd3 + 20'h1_0000;
   assign early_in = (tag2_ff.branch == BR_POLY) ? poly_acc[49:32] : lin_acc[19:2];

   // Main divider: r < -1 forms x(x-1)/(x^2+1); r >= 2 forms 2^46 / den.
   always_comb begin
      case (tag2_ff.branch)
         BR_NEG_FAR: begin
            rem_init = m1_2_ff;
            den_init = m2_2_ff + 64'h1_0000_0000;
         end
         BR_HIGH: begin
            rem_init = 64'h4000_0000;
            den_init = m1_2_ff - 64'h1_0000_0000;
         end
         default: begin
            rem_init = '0;
            den_init = 64'd1;
         end
      endcase
   end

   // Cap divider: 2^34 / (x+1); the first quotient bit is resolved here.
   assign cap_top   = 34'h4_0000;
   assign cq_init   = (cap_top >= {1'b0, cden2_ff});
   assign crem_init = cq_init ? CAP_WIDTH'(cap_top - {1'b0, cden2_ff})
                              : CAP_WIDTH'(cap_top);

   // ---------------- Divider steps ------------------------------------------
   logic                  dv_ff    [0:DIV_STEPS];
   logic [REM_WIDTH-1:0]  rem_ff   [0:DIV_STEPS];
   logic [REM_WIDTH-1:0]  den_ff   [0:DIV_STEPS];
   logic [DIV_STEPS-1:0]  q_ff     [0:DIV_STEPS];
   logic [CAP_WIDTH-1:0]  crem_ff  [0:DIV_STEPS];
   logic [CAP_WIDTH-1:0]  cden_ff  [0:DIV_STEPS];
   logic [CAPQ_WIDTH-1:0] cq_ff    [0:DIV_STEPS];
   logic [PHI_WIDTH-1:0]  early_ff [0:DIV_STEPS];
   tag_type               dtag_ff  [0:DIV_STEPS];

   // Each stage shifts one bit of the partial remainder and subtracts the divisor when it fits.
   logic [REM_WIDTH-1:0]  sh_in    [1:DIV_STEPS];
   logic [CAP_WIDTH:0]    csh_in   [1:DIV_STEPS];

   always_comb begin
      for (int k = 1; k <= DIV_STEPS; k++) begin
         sh_in[k]  = {rem_ff[k-1][REM_WIDTH-2:0], 1'b0};
         csh_in[k] = {crem_ff[k-1], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= DIV_STEPS; k++) begin
            dv_ff[k] <= 1'b0;
         end
      end else begin
         dv_ff[0] <= v2_ff;
         for (int k = 1; k <= DIV_STEPS; k++) begin
            dv_ff[k] <= dv_ff[k-1];
         end
      end
      rem_ff[0]   <= rem_init;
      den_ff[0]   <= den_init;
      q_ff[0]     <= '0;
      crem_ff[0]  <= crem_init;
      cden_ff[0]  <= cden2_ff;
      cq_ff[0]    <= CAPQ_WIDTH'(cq_init);
      early_ff[0] <= early_in;
      dtag_ff[0]  <= tag2_ff;
      for (int k = 1; k <= DIV_STEPS; k++) begin
         if (sh_in[k] >= den_ff[k-1]) begin
            rem_ff[k] <= sh_in[k] - den_ff[k-1];
            q_ff[k]   <= {q_ff[k-1][DIV_STEPS-2:0], 1'b1};
         end else begin
            rem_ff[k] <= sh_in[k];
            q_ff[k]   <= {q_ff[k-1][DIV_STEPS-2:0], 1'b0};
         end
         if (csh_in[k] >= {1'b0, cden_ff[k-1]}) begin
            crem_ff[k] <= CAP_WIDTH'(csh_in[k] - {1'b0, cden_ff[k-1]});
            cq_ff[k]   <= {cq_ff[k-1][CAPQ_WIDTH-2:0], 1'b1};
         end else begin
            crem_ff[k] <= CAP_WIDTH'(csh_in[k]);
            cq_ff[k]   <= {cq_ff[k-1][CAPQ_WIDTH-2:0], 1'b0};
         end
         den_ff[k]   <= den_ff[k-1];
         cden_ff[k]  <= cden_ff[k-1];
         early_ff[k] <= early_ff[k-1];
         dtag_ff[k]  <= dtag_ff[k-1];
      end
   end

   // ---------------- Limiter select -----------------------------------------
   logic [CAPQ_WIDTH-1:0] dip;
   logic [PHI_WIDTH-1:0]  high_phi;
   logic [PHI_WIDTH-1:0]  phi_in;
   logic                  vf_ff;
   logic [PHI_WIDTH-1:0]  phif_ff;
   tag_type               tagf_ff;

   // The high branch is 2 minus the rounded-up quotient.
   assign dip      = {1'b0, q_ff[DIV_STEPS]}
                     + CAPQ_WIDTH'(rem_ff[DIV_STEPS] != '0);
   assign high_phi = 18'h2_0000 - {1'b0, dip};

   always_comb begin
      case (dtag_ff[DIV_STEPS].branch)
         BR_NEG_FAR:  phi_in = {2'b00, q_ff[DIV_STEPS]};
         BR_NEG_ZERO: phi_in = '0;
         BR_POLY:     phi_in = early_ff[DIV_STEPS];
         BR_LINEAR:   phi_in = early_ff[DIV_STEPS];
         BR_HIGH: begin
            if (dtag_ff[DIV_STEPS].mode && ({1'b0, cq_ff[DIV_STEPS]} < high_phi)) begin
               phi_in = {1'b0, cq_ff[DIV_STEPS]};
            end else begin
               phi_in = high_phi;
            end
         end
         default:     phi_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vf_ff <= 1'b0;
      end else begin
         vf_ff <= dv_ff[DIV_STEPS];
      end
      phif_ff <= phi_in;
      tagf_ff <= dtag_ff[DIV_STEPS];
   end

   // ---------------- Product ------------------------------------------------
   logic [DATA_WIDTH-1:0] mag;
   logic [PROD_WIDTH-1:0] prod_in;
   logic                  vm_ff;
   logic [PROD_WIDTH-FRAC_BITS-1:0] prodm_ff;
   logic [PHI_WIDTH-1:0]  phim_ff;
   logic                  negm_ff;

   assign mag     = tagf_ff.grad[DATA_WIDTH-1] ? (32'd0 - tagf_ff.grad) : tagf_ff.grad;
   assign prod_in = {{DATA_WIDTH{1'b0}}, phif_ff} * {{PHI_WIDTH{1'b0}}, mag};

   always_ff @(posedge clock) begin
      if (reset) begin
         vm_ff <= 1'b0;
      end else begin
         vm_ff <= vf_ff;
      end
      prodm_ff <= prod_in[PROD_WIDTH-1:FRAC_BITS];
      phim_ff  <= phif_ff;
      negm_ff  <= tagf_ff.grad[DATA_WIDTH-1];
   end

   // ---------------- Saturation and result register -------------------------
   localparam logic [PROD_WIDTH-FRAC_BITS-1:0] NegLimit = 34'h0_8000_0000;
   localparam logic [PROD_WIDTH-FRAC_BITS-1:0] PosLimit = 34'h0_7FFF_FFFF;
   logic [PROD_WIDTH-FRAC_BITS-1:0] sat;
   logic [DATA_WIDTH-1:0]           res_in;

   always_comb begin
      if (negm_ff) begin
         sat    = (prodm_ff > NegLimit) ? NegLimit : prodm_ff;
         res_in = 32'd0 - sat[DATA_WIDTH-1:0];
      end else begin
         sat    = (prodm_ff > PosLimit) ? PosLimit : prodm_ff;
         res_in = sat[DATA_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= vm_ff;
      end
      rsp_limited_gradient <= res_in;
      rsp_limiter_value    <= phim_ff;
   end

   // ---------------- Assertions ---------------------------------------------
   // Every result transfer comes from a start transfer a fixed time earlier.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, PIPE_LATENCY))
      else $error("result without matching start");

   // The limiter never exceeds two.
   a_phi_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_limiter_value <= 18'h2_0000))
      else $error("limiter value above two");

   // A zero limiter value must give a zero limited gradient.
   a_zero_phi: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_limiter_value == '0)) |-> (rsp_limited_gradient == '0))
      else $error("non-zero gradient with zero limiter");

endmodule
